@@ rtl/ssl_pkg.sv @@
`default_nettype none
package ssl_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int NUM_OUTPUTS = 4;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  localparam int MAP_W = 17;
  localparam int ADDR_W = 15;
  localparam int MAP_EN_BIT = 15;
  localparam int MAP_MERGE_BIT = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT0_MAP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT1_MAP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT2_MAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT3_MAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WINDOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_TIMEOUT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_WINDOW = 3'd6;

  localparam logic [1:0] STATUS_NORMAL = 2'd0;
  localparam logic [1:0] STATUS_CONFLICT = 2'd1;
  localparam logic [1:0] STATUS_MERGING = 2'd2;

  typedef struct packed {
    logic [31:0] ip;
    logic [7:0]  protocol;
    logic [15:0] universe;
    logic [7:0]  priority_lvl;
    logic [31:0] last_seen;
    logic [31:0] window_start;
    logic [15:0] window_count;
    logic [15:0] rate;
  } entry_t;

endpackage
`default_nettype wire

@@ rtl/ssl_item_if.sv @@
`default_nettype none
interface ssl_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] now_ms;
  logic [31:0] source_ip;
  logic [7:0]  source_protocol;
  logic [15:0] universe_id;
  logic [7:0]  source_priority;
  logic [31:0] query_window_ms;

  modport source(output valid, cmd, now_ms, source_ip, source_protocol, universe_id,
                 source_priority, query_window_ms, input ready);
  modport sink(input valid, cmd, now_ms, source_ip, source_protocol, universe_id,
               source_priority, query_window_ms, output ready);
endinterface
`default_nettype wire

@@ rtl/ssl_result_if.sv @@
`default_nettype none
interface ssl_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  slot_index;
  logic        fresh_slot;
  logic [15:0] frame_rate;
  logic [4:0]  active_count;
  logic [4:0]  universe_sources;
  logic [1:0]  source_status;

  modport source(output valid, slot_index, fresh_slot, frame_rate, active_count,
                 universe_sources, source_status, input ready);
  modport sink(input valid, slot_index, fresh_slot, frame_rate, active_count,
               universe_sources, source_status, output ready);
endinterface
`default_nettype wire

@@ rtl/ssl_cell.sv @@
`default_nettype none
module ssl_cell
  import ssl_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   shift,
  input  wire entry_t d,
  output entry_t      q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sender_slot_table.sv @@
// A poll needs one lap of the slot ring and a frame needs two.
// The slot records circulate through a ring of cells, one slot passing the head per cycle:
// a frame needs one lap to choose its slot and a second lap to write it back.
// One item is in work at a time; a result waits in the output register while the next
// item is accepted. Synchronous reset empties every slot and restores register defaults.
`default_nettype none
module sender_slot_table
  import ssl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  ssl_item_if.sink                   item,
  ssl_result_if.source               result
);

  typedef enum logic [3:0] {
    IDLE  = 4'b0001,
    SCAN  = 4'b0010,
    WRITE = 4'b0100,
    DONE  = 4'b1000
  } state_t;

  state_t state;

  logic [MAP_W-1:0] out_map [NUM_OUTPUTS];
  logic [31:0] active_window;
  logic [31:0] source_timeout;
  logic [15:0] rate_window;

  logic        cmd_r;
  logic [31:0] now_r;
  logic [31:0] ip_r;
  logic [7:0]  proto_r;
  logic [15:0] uni_r;
  logic [7:0]  prio_r;
  logic [31:0] qwin_r;

  logic [SLOT_W-1:0] step;
  logic              step_last;

  logic              match_found, empty_found, unmap_found;
  logic [SLOT_W-1:0] match_idx, empty_idx, unmap_idx, oldest_idx;
  logic [31:0]       oldest_ms;
  logic [CNT_W-1:0]  act_cnt, uni_cnt;
  logic [1:0]        port_cnt [NUM_OUTPUTS];

  logic              res_fresh;
  logic [15:0]       res_rate;

  entry_t cell_q [NUM_SLOTS];
  entry_t head, wb;
  logic   ring_shift;

  assign head = cell_q[0];
  assign ring_shift = (state == SCAN) || (state == WRITE);
  assign step_last = (step == SLOT_W'(NUM_SLOTS - 1));

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    entry_t d_k;
    if (k == NUM_SLOTS - 1) begin : g_tail
      assign d_k = wb;
    end else begin : g_mid
      assign d_k = cell_q[k+1];
    end
    ssl_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(ring_shift),
      .d    (d_k),
      .q    (cell_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int o = 0; o < NUM_OUTPUTS; o++) out_map[o] <= '0;
      active_window  <= 32'd2500;
      source_timeout <= 32'd2500;
      rate_window    <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUTPUT0_MAP: out_map[0] <= cfg_data[MAP_W-1:0];
        REG_OUTPUT1_MAP: if (NUM_OUTPUTS > 1) out_map[1 % NUM_OUTPUTS] <= cfg_data[MAP_W-1:0];
        REG_OUTPUT2_MAP: if (NUM_OUTPUTS > 2) out_map[2 % NUM_OUTPUTS] <= cfg_data[MAP_W-1:0];
        REG_OUTPUT3_MAP: if (NUM_OUTPUTS > 3) out_map[3 % NUM_OUTPUTS] <= cfg_data[MAP_W-1:0];
        REG_ACTIVE_WINDOW:  active_window  <= cfg_data;
        REG_SOURCE_TIMEOUT: source_timeout <= cfg_data;
        REG_RATE_WINDOW:    rate_window    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic        head_empty, head_match, head_mapped, head_older;
  logic [31:0] head_age;
  logic [NUM_OUTPUTS-1:0] port_hit;

  always_comb begin
    head_empty  = (head.ip == 32'd0);
    head_match  = (head.ip == ip_r) && (head.protocol == proto_r);
    head_age    = now_r - head.last_seen;
    head_older  = (step == '0) || (head.last_seen < oldest_ms);
    head_mapped = 1'b0;
    for (int o = 0; o < NUM_OUTPUTS; o++) begin
      if (out_map[o][MAP_EN_BIT] && ({1'b0, out_map[o][ADDR_W-1:0]} == head.universe)) begin
        head_mapped = 1'b1;
      end
      port_hit[o] = !head_empty && (head_age <= source_timeout) &&
                    ({1'b0, out_map[o][ADDR_W-1:0]} == head.universe);
    end
  end

  logic [SLOT_W-1:0] chosen;
  always_comb begin
    priority if (match_found) chosen = match_idx;
    else if (empty_found) chosen = empty_idx;
    else if (unmap_found) chosen = unmap_idx;
    else chosen = oldest_idx;
  end

  entry_t upd;
  logic [15:0] wc_inc;
  always_comb begin
    upd = head;
    if (!match_found) begin
      upd.window_start = now_r;
      upd.window_count = '0;
      upd.rate         = '0;
    end
    upd.ip           = ip_r;
    upd.protocol     = proto_r;
    upd.universe     = uni_r;
    upd.priority_lvl = prio_r;
    upd.last_seen    = now_r;
    wc_inc = (upd.window_count == 16'hFFFF) ? upd.window_count : upd.window_count + 16'd1;
    upd.window_count = wc_inc;
    if ((now_r - upd.window_start) >= {16'd0, rate_window}) begin
      upd.rate         = wc_inc;
      upd.window_start = now_r;
      upd.window_count = 16'd1;
    end
    wb = ((state == WRITE) && (step == chosen)) ? upd : head;
  end

  logic any_en, any_merge, is_merging, is_conflict;
  logic [1:0] status;
  always_comb begin
    any_en = 1'b0;
    any_merge = 1'b0;
    is_merging = 1'b0;
    is_conflict = 1'b0;
    for (int o = 0; o < NUM_OUTPUTS; o++) begin
      if (out_map[o][MAP_EN_BIT]) begin
        any_en = 1'b1;
        if (out_map[o][MAP_MERGE_BIT]) any_merge = 1'b1;
        if (port_cnt[o] == 2'd2) begin
          is_conflict = 1'b1;
          if (out_map[o][MAP_MERGE_BIT]) is_merging = 1'b1;
        end
      end
    end
    priority if (!any_en || !any_merge) status = STATUS_NORMAL;
    else if (is_merging) status = STATUS_MERGING;
    else if (is_conflict) status = STATUS_CONFLICT;
    else status = STATUS_NORMAL;
  end

  assign item.ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      cmd_r   <= item.cmd;
      now_r   <= item.now_ms;
      ip_r    <= item.source_ip;
      proto_r <= item.source_protocol;
      uni_r   <= item.universe_id;
      prio_r  <= item.source_priority;
      qwin_r  <= item.query_window_ms;
    end
    if ((state == WRITE) && (step == chosen)) begin
      res_fresh <= !match_found;
      res_rate  <= upd.rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
      result.valid <= 1'b0;
      match_found <= 1'b0;
      empty_found <= 1'b0;
      unmap_found <= 1'b0;
      act_cnt <= '0;
      uni_cnt <= '0;
      for (int o = 0; o < NUM_OUTPUTS; o++) port_cnt[o] <= '0;
    end else begin
      if (result.valid && result.ready && (state != DONE)) result.valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (item.valid) begin
            state <= SCAN;
            step  <= '0;
            match_found <= 1'b0;
            empty_found <= 1'b0;
            unmap_found <= 1'b0;
            act_cnt <= '0;
            uni_cnt <= '0;
            for (int o = 0; o < NUM_OUTPUTS; o++) port_cnt[o] <= '0;
          end
        end
        SCAN: begin
          if (head_match && !match_found) begin
            match_found <= 1'b1;
            match_idx   <= step;
          end
          if (head_empty && !empty_found) begin
            empty_found <= 1'b1;
            empty_idx   <= step;
          end
          if (!head_empty && !head_mapped && !unmap_found) begin
            unmap_found <= 1'b1;
            unmap_idx   <= step;
          end
          if (head_older) begin
            oldest_ms  <= head.last_seen;
            oldest_idx <= step;
          end
          if (!head_empty && (head_age <= active_window)) act_cnt <= act_cnt + CNT_W'(1);
          if (!head_empty && (head.universe == uni_r) && (head_age <= qwin_r)) begin
            uni_cnt <= uni_cnt + CNT_W'(1);
          end
          for (int o = 0; o < NUM_OUTPUTS; o++) begin
            if (port_hit[o] && (port_cnt[o] != 2'd2)) port_cnt[o] <= port_cnt[o] + 2'd1;
          end
          step <= step_last ? '0 : step + SLOT_W'(1);
          if (step_last) state <= cmd_r ? DONE : WRITE;
        end
        WRITE: begin
          step <= step_last ? '0 : step + SLOT_W'(1);
          if (step_last) state <= DONE;
        end
        DONE: begin
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            if (cmd_r) begin
              result.slot_index       <= '0;
              result.fresh_slot       <= 1'b0;
              result.frame_rate       <= '0;
              result.active_count     <= 5'(act_cnt);
              result.universe_sources <= 5'(uni_cnt);
              result.source_status    <= status;
            end else begin
              result.slot_index       <= 4'(chosen);
              result.fresh_slot       <= res_fresh;
              result.frame_rate       <= res_rate;
              result.active_count     <= '0;
              result.universe_sources <= '0;
              result.source_status    <= STATUS_NORMAL;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ bench/tb_sender_slot_table.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_sender_slot_table;
  import ssl_pkg::*;

  typedef struct packed {
    logic [3:0]  slot_index;
    logic        fresh_slot;
    logic [15:0] frame_rate;
    logic [4:0]  active_count;
    logic [4:0]  universe_sources;
    logic [1:0]  source_status;
  } table_reply_t;

  typedef enum logic {CMD_FRAME = 1'b0, CMD_POLL = 1'b1} cmd_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ssl_item_if item ();
  ssl_result_if result ();

  sender_slot_table uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item(item.sink), .result(result.source)
  );

  logic [16:0] map_reg [NUM_OUTPUTS];
  logic [31:0] active_win;
  logic [31:0] timeout_win;
  logic [15:0] rate_win;
  logic [31:0] tbl_ip [NUM_SLOTS];
  logic [7:0]  tbl_proto [NUM_SLOTS];
  logic [15:0] tbl_uni [NUM_SLOTS];
  logic [31:0] tbl_seen [NUM_SLOTS];
  logic [31:0] tbl_wstart [NUM_SLOTS];
  logic [15:0] tbl_wcount [NUM_SLOTS];
  logic [15:0] tbl_rate [NUM_SLOTS];

  table_reply_t pending_replies[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int polls = 0;
  logic [31:0] clock_ms = 32'd0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("tb_sender_slot_table: timeout");
    $display("tb_sender_slot_table: done, errors");
    $finish;
  end

  function automatic int count_uni(logic [15:0] uni, logic [31:0] now, logic [31:0] win);
    int n;
    n = 0;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (tbl_ip[i] != 0 && tbl_uni[i] == uni && (now - tbl_seen[i]) <= win) n++;
    return n;
  endfunction

  function automatic logic [1:0] status_now(logic [31:0] now);
    for (int o = 0; o < NUM_OUTPUTS; o++)
      if (map_reg[o][MAP_EN_BIT] && map_reg[o][MAP_MERGE_BIT] &&
          count_uni({1'b0, map_reg[o][14:0]}, now, timeout_win) > 1)
        return STATUS_MERGING;
    for (int o = 0; o < NUM_OUTPUTS; o++)
      if (map_reg[o][MAP_EN_BIT] && map_reg[o][MAP_MERGE_BIT]) begin
        for (int p = 0; p < NUM_OUTPUTS; p++)
          if (map_reg[p][MAP_EN_BIT] &&
              count_uni({1'b0, map_reg[p][14:0]}, now, timeout_win) > 1)
            return STATUS_CONFLICT;
        return STATUS_NORMAL;
      end
    return STATUS_NORMAL;
  endfunction

  function automatic bit uni_mapped(logic [15:0] uni);
    for (int o = 0; o < NUM_OUTPUTS; o++)
      if (map_reg[o][MAP_EN_BIT] && {1'b0, map_reg[o][14:0]} == uni) return 1'b1;
    return 1'b0;
  endfunction

  function automatic table_reply_t predict_reply(cmd_e cmd, logic [31:0] now,
      logic [31:0] ip, logic [7:0] proto, logic [15:0] uni, logic [31:0] qwin);
    table_reply_t r;
    int slot;
    int act;
    logic [31:0] oldest;
    r = '0;
    if (cmd == CMD_POLL) begin
      act = 0;
      for (int i = 0; i < NUM_SLOTS; i++)
        if (tbl_ip[i] != 0 && (now - tbl_seen[i]) <= active_win) act++;
      r.active_count = act[4:0];
      r.universe_sources = 5'(count_uni(uni, now, qwin));
      r.source_status = status_now(now);
      return r;
    end
    slot = -1;
    for (int i = 0; i < NUM_SLOTS && slot < 0; i++)
      if (tbl_ip[i] == ip && tbl_proto[i] == proto) slot = i;
    for (int i = 0; i < NUM_SLOTS && slot < 0; i++)
      if (tbl_ip[i] == 0) slot = i;
    for (int i = 0; i < NUM_SLOTS && slot < 0; i++)
      if (tbl_ip[i] != 0 && !uni_mapped(tbl_uni[i])) slot = i;
    if (slot < 0) begin
      slot = 0;
      oldest = tbl_seen[0];
      for (int i = 1; i < NUM_SLOTS; i++)
        if (tbl_seen[i] < oldest) begin
          oldest = tbl_seen[i];
          slot = i;
        end
    end
    r.fresh_slot = !(tbl_ip[slot] == ip && tbl_proto[slot] == proto);
    if (r.fresh_slot) begin
      tbl_wstart[slot] = now;
      tbl_wcount[slot] = 16'd0;
      tbl_rate[slot] = 16'd0;
    end
    tbl_ip[slot] = ip;
    tbl_proto[slot] = proto;
    tbl_uni[slot] = uni;
    tbl_seen[slot] = now;
    if (tbl_wcount[slot] != 16'hFFFF) tbl_wcount[slot]++;
    if ((now - tbl_wstart[slot]) >= {16'd0, rate_win}) begin
      tbl_rate[slot] = tbl_wcount[slot];
      tbl_wstart[slot] = now;
      tbl_wcount[slot] = 16'd1;
    end
    r.slot_index = slot[3:0];
    r.frame_rate = tbl_rate[slot];
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    item.valid <= 1'b0;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OUTPUT0_MAP, REG_OUTPUT1_MAP, REG_OUTPUT2_MAP, REG_OUTPUT3_MAP: begin
        map_reg[idx[1:0]] = val[16:0];
      end
      REG_ACTIVE_WINDOW: active_win = val;
      REG_SOURCE_TIMEOUT: timeout_win = val;
      REG_RATE_WINDOW: rate_win = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    item.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (2 * NUM_SLOTS + 8) @(posedge clk);
  endtask

  task automatic send_item(cmd_e cmd, logic [31:0] now, logic [31:0] ip, logic [7:0] proto,
                           logic [15:0] uni, logic [7:0] prio, logic [31:0] qwin);
    int gap;
    item.valid <= 1'b1;
    item.cmd <= cmd;
    item.now_ms <= now;
    item.source_ip <= ip;
    item.source_protocol <= proto;
    item.universe_id <= uni;
    item.source_priority <= prio;
    item.query_window_ms <= qwin;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    pending_replies.push_back(predict_reply(cmd, now, ip, proto, uni, qwin));
    sent++;
    if (cmd == CMD_POLL) polls++;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    table_reply_t got;
    table_reply_t exp;
    if (!rst && result.valid && result.ready) begin
      got = '{result.slot_index, result.fresh_slot, result.frame_rate,
              result.active_count, result.universe_sources, result.source_status};
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp = pending_replies.pop_front();
        checked++;
        if (got.slot_index !== exp.slot_index)
          $display("%0t: slot_index exp %0d got %0d", $time, exp.slot_index, got.slot_index);
        if (got.fresh_slot !== exp.fresh_slot)
          $display("%0t: fresh_slot exp %0d got %0d", $time, exp.fresh_slot, got.fresh_slot);
        if (got.frame_rate !== exp.frame_rate)
          $display("%0t: frame_rate exp %0d got %0d", $time, exp.frame_rate, got.frame_rate);
        if (got.active_count !== exp.active_count)
          $display("%0t: active_count exp %0d got %0d", $time, exp.active_count,
                   got.active_count);
        if (got.universe_sources !== exp.universe_sources)
          $display("%0t: universe_sources exp %0d got %0d", $time, exp.universe_sources,
                   got.universe_sources);
        if (got.source_status !== exp.source_status)
          $display("%0t: source_status exp %0d got %0d", $time, exp.source_status,
                   got.source_status);
        if (got !== exp) errors++;
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result.ready <= 1'b0;
    end else if (result.valid && result.ready) begin
      stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
      result.ready <= 1'b1;
    end else begin
      result.ready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_ip();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return $urandom;
      default: return 32'h0A000000 | $urandom_range(1, 24);
    endcase
  endfunction

  function automatic logic [15:0] pick_uni();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(1, 4));
  endfunction

  task automatic random_frames_and_polls(int count, int max_step);
    cmd_e cmd;
    for (int k = 0; k < count; k++) begin
      clock_ms = clock_ms + $urandom_range(0, max_step);
      cmd = ($urandom_range(0, 3) == 0) ? CMD_POLL : CMD_FRAME;
      send_item(cmd, clock_ms, pick_ip(), ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd1,
                pick_uni(), 8'($urandom),
                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3000));
    end
  endtask

  task automatic test_directed();
    send_item(CMD_POLL, 32'd0, 32'd0, 8'd0, 16'd0, 8'd0, 32'd0);
    send_item(CMD_FRAME, 32'd0, 32'd0, 8'd0, 16'd0, 8'd0, 32'd0);
    send_item(CMD_FRAME, 32'd5, 32'hFFFFFFFF, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFFFFFF);
    send_item(CMD_FRAME, 32'd10, 32'hFFFFFFFF, 8'hFF, 16'h8001, 8'h00, 32'd0);
    send_item(CMD_FRAME, 32'd1500, 32'hFFFFFFFF, 8'hFF, 16'h0001, 8'h7F, 32'd0);
    send_item(CMD_FRAME, 32'd1600, 32'h0A000001, 8'd1, 16'd1, 8'd1, 32'd0);
    send_item(CMD_FRAME, 32'd1700, 32'h0A000002, 8'd1, 16'd1, 8'd1, 32'd0);
    send_item(CMD_POLL, 32'd1800, 32'hFFFFFFFF, 8'hFF, 16'd1, 8'hFF, 32'hFFFFFFFF);
    send_item(CMD_POLL, 32'hFFFFFFFF, 32'd0, 8'd0, 16'd1, 8'd0, 32'd0);
    wait_drained();
    write_reg(REG_OUTPUT0_MAP, 32'h18001);
    write_reg(REG_OUTPUT1_MAP, 32'h08001);
    write_reg(REG_OUTPUT3_MAP, 32'h1FFFF);
    send_item(CMD_POLL, 32'd1800, 32'd0, 8'd0, 16'd1, 8'd0, 32'd100);
    wait_drained();
    write_reg(REG_OUTPUT0_MAP, 32'h08001);
    send_item(CMD_POLL, 32'd1800, 32'd0, 8'd0, 16'd1, 8'd0, 32'd100);
    wait_drained();
    clock_ms = 32'd2000;
  endtask

  task automatic test_eviction();
    write_reg(REG_OUTPUT0_MAP, 32'h08000 | 32'd1);
    write_reg(REG_OUTPUT1_MAP, 32'h18000 | 32'd2);
    write_reg(REG_OUTPUT2_MAP, 32'h18000 | 32'd3);
    write_reg(REG_OUTPUT3_MAP, 32'h08000 | 32'd4);
    for (int k = 0; k < 40; k++) begin
      clock_ms = clock_ms + $urandom_range(1, 50);
      send_item(CMD_FRAME, clock_ms, 32'h0B000000 | 32'(k), 8'd2,
                16'($urandom_range(1, 4)), 8'd9, 32'd0);
    end
    wait_drained();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 8; ph++) begin
      for (int o = 0; o < NUM_OUTPUTS; o++)
        write_reg(o[CFG_IDX_W-1:0], ph == 0 ? 32'h1FFFF :
                  ph == 1 ? 32'd0 : ($urandom & 32'h18000) | $urandom_range(1, 4));
      write_reg(REG_ACTIVE_WINDOW, ph == 0 ? 32'hFFFFFFFF : ph == 1 ? 32'd0 :
                $urandom_range(0, 4000));
      write_reg(REG_SOURCE_TIMEOUT, ph == 0 ? 32'd0 : ph == 1 ? 32'hFFFFFFFF :
                $urandom_range(0, 4000));
      write_reg(REG_RATE_WINDOW, ph == 0 ? 32'd1 : ph == 1 ? 32'hFFFF :
                $urandom_range(1, 1500));
      random_frames_and_polls(150, ph == 3 ? 100000 : 200);
      wait_drained();
    end
    write_reg(3'd7, $urandom);
    clock_ms = 32'hFFFFF000;
    random_frames_and_polls(50, 300);
    wait_drained();
  endtask

  initial begin
    item.valid = 1'b0;
    item.cmd = CMD_FRAME;
    item.now_ms = '0;
    item.source_ip = '0;
    item.source_protocol = '0;
    item.universe_id = '0;
    item.source_priority = '0;
    item.query_window_ms = '0;
    for (int o = 0; o < NUM_OUTPUTS; o++) map_reg[o] = '0;
    active_win = 32'd2500;
    timeout_win = 32'd2500;
    rate_win = 16'd1000;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_ip[i] = '0; tbl_proto[i] = '0; tbl_uni[i] = '0; tbl_seen[i] = '0;
      tbl_wstart[i] = '0; tbl_wcount[i] = '0; tbl_rate[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_eviction();
    test_random_settings();
    wait_drained();
    $display("Sent %0d items (%0d polls) over eight register settings, %0d results checked.",
             sent, polls, checked);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("tb_sender_slot_table: done, clean");
    end else begin
      $display("tb_sender_slot_table: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
